### rtl/bpfb_pkg.sv
// Shared types and constants for the band-pass filter bank power meter.
package bpfb_pkg;

  localparam logic [1:0] OP_AUDIO = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic CFG_STEREO = 1'b0;
  localparam logic CFG_BANDS  = 1'b1;

  localparam int GUARD_BITS = 9;
  localparam int COUNT_BITS = 16;

endpackage

### rtl/bpfb_biquad.sv
// Shared biquad unit: one multiplier, three products per step, formed one after another.
module bpfb_biquad import bpfb_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS = 28
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [COEF_BITS-1:0] b0,
  input  logic signed [COEF_BITS-1:0] a1,
  input  logic signed [COEF_BITS-1:0] a2,
  input  logic signed [SAMPLE_BITS+15:0] d1,
  input  logic signed [SAMPLE_BITS+15:0] d2,
  output logic done,
  output logic signed [SAMPLE_BITS-1:0] y,
  output logic signed [SAMPLE_BITS+15:0] d1_new,
  output logic signed [SAMPLE_BITS+15:0] d2_new
);
  localparam int SB = SAMPLE_BITS + 16;
  localparam int PB = SAMPLE_BITS + COEF_BITS;
  localparam int PS = COEF_BITS - 4 - GUARD_BITS;
  localparam int WB = SB + 2;
  localparam logic signed [WB-1:0] Y_MAX = WB'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [WB-1:0] Y_MIN = -Y_MAX - WB'(1);

  logic [1:0] step;
  logic busy;
  logic signed [COEF_BITS-1:0] mc;
  logic signed [SAMPLE_BITS-1:0] mx;
  logic signed [PB-1:0] prod;
  logic signed [WB-1:0] fwd, pshift, yfull, yshift, n1, n2;
  logic signed [SAMPLE_BITS-1:0] yq;

  function automatic logic signed [SB-1:0] sat_state(input logic signed [WB-1:0] v);
    logic signed [WB-1:0] hi, lo;
    hi = WB'({1'b0, {(SB-1){1'b1}}});
    lo = -hi - WB'(1);
    if (v > hi) return hi[SB-1:0];
    if (v < lo) return lo[SB-1:0];
    return v[SB-1:0];
  endfunction

  always_comb begin
    case (step)
      2'd0:    mc = b0;
      2'd1:    mc = a1;
      default: mc = a2;
    endcase
    mx = (step == 2'd0) ? x : y;
    prod = PB'(mc) * PB'(mx);
    pshift = WB'(prod >>> PS);
    // output sample is formed in the b0 cycle and held in y for the feedback products
    yfull = pshift + WB'(d1);
    yshift = yfull >>> GUARD_BITS;
    if (yshift > Y_MAX)
      yq = Y_MAX[SAMPLE_BITS-1:0];
    else if (yshift < Y_MIN)
      yq = Y_MIN[SAMPLE_BITS-1:0];
    else
      yq = yshift[SAMPLE_BITS-1:0];
    n1 = WB'(d2) - pshift;
    n2 = -fwd - pshift;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 2'd0;
    end else if (busy) begin
      case (step)
        2'd0: begin
          fwd <= pshift;
          y <= yq;
          step <= 2'd1;
        end
        2'd1: begin
          d1_new <= sat_state(n1);
          step <= 2'd2;
        end
        default: begin
          d2_new <= sat_state(n2);
          busy <= 1'b0;
          done <= 1'b1;
          step <= 2'd0;
        end
      endcase
    end
  end
endmodule

### rtl/bandpass_filter_bank_power_meter.sv
// Band-pass filter bank power meter: top level, sequencer and band state.
// Audio word: per band (and per channel in stereo) the filter forms its 3 products on the
// shared multiplier, then an accumulate state adds the band power (N = bands in use).
// Hop end then emits N result words, one per cycle while out_ready is high; a clear
// zeroes the filter state of all BANDS bands. One word at a time; ready only when idle.
// Reset: synchronous, filter, coefficient and meter state zero, band_count 16, stereo off; state in flip-flops.
module bandpass_filter_bank_power_meter import bpfb_pkg::*; #(
  parameter int BANDS = 16,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS = 28
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [4:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] opcode,
  input  logic signed [SAMPLE_BITS-1:0] primary_sample,
  input  logic signed [SAMPLE_BITS-1:0] secondary_sample,
  input  logic hop_end,
  input  logic [3:0] coef_band,
  input  logic signed [COEF_BITS-1:0] coef_gain,
  input  logic signed [COEF_BITS-1:0] coef_fb_one,
  input  logic signed [COEF_BITS-1:0] coef_fb_two,
  output logic out_valid,
  input  logic out_ready,
  output logic [3:0] band_index,
  output logic [2*SAMPLE_BITS-2:0] peak_power,
  output logic [62:0] sum_power,
  output logic [15:0] sample_count,
  output logic last
);
  localparam int SB = SAMPLE_BITS + 16;
  localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int PKB = 2 * SAMPLE_BITS - 1;
  localparam int SQB = 2 * SAMPLE_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILT  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic stereo_mode;
  logic [4:0] band_count;
  logic [BW-1:0] band;
  logic [BW:0] nbands;
  logic chan;
  logic hop;
  logic [COUNT_BITS-1:0] hop_samples;
  logic signed [SAMPLE_BITS-1:0] xp, xs;
  logic [SQB-1:0] sq_p;

  logic signed [SB-1:0] pd1 [BANDS];
  logic signed [SB-1:0] pd2 [BANDS];
  logic signed [SB-1:0] sd1 [BANDS];
  logic signed [SB-1:0] sd2 [BANDS];
  logic signed [COEF_BITS-1:0] cb0 [BANDS];
  logic signed [COEF_BITS-1:0] ca1 [BANDS];
  logic signed [COEF_BITS-1:0] ca2 [BANDS];
  logic [62:0] psum [BANDS];
  logic [PKB-1:0] ppeak [BANDS];

  logic bq_start, bq_done;
  logic signed [SB-1:0] bq_d1n, bq_d2n;
  logic signed [SAMPLE_BITS-1:0] bq_y;
  logic [SQB-1:0] sq;
  logic [SQB:0] pw_sum;
  logic [SQB-1:0] pw;
  logic [63:0] sum_add;
  logic [BW:0] bands_in_use;

  assign sq = SQB'(bq_y * bq_y);
  assign pw_sum = {1'b0, sq_p} + {1'b0, sq};
  assign pw = stereo_mode ? pw_sum[SQB:1] : sq_p;
  assign sum_add = {1'b0, psum[band]} + 64'(pw);

  always_comb begin
    if (band_count == 5'd0) bands_in_use = (BW+1)'(1);
    else if (32'(band_count) > BANDS) bands_in_use = (BW+1)'(BANDS);
    else bands_in_use = (BW+1)'(band_count);
  end

  bpfb_biquad #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) u_biquad (
    .clk, .rst, .start(bq_start),
    .x(chan ? xs : xp), .b0(cb0[band]), .a1(ca1[band]), .a2(ca2[band]),
    .d1(chan ? sd1[band] : pd1[band]), .d2(chan ? sd2[band] : pd2[band]),
    .done(bq_done), .y(bq_y), .d1_new(bq_d1n), .d2_new(bq_d2n)
  );

  assign in_ready = (state == S_IDLE);
  assign bq_start = (state == S_FILT);
  assign out_valid = (state == S_EMIT);
  assign band_index = 4'(band);
  assign peak_power = ppeak[band];
  assign sum_power = psum[band];
  assign sample_count = hop_samples;
  assign last = ((BW+1)'(band) + (BW+1)'(1) == nbands);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stereo_mode <= 1'b0;
      band_count <= 5'd16;
      hop_samples <= '0;
      band <= '0;
      chan <= 1'b0;
      for (int i = 0; i < BANDS; i++) begin
        pd1[i] <= '0; pd2[i] <= '0; sd1[i] <= '0; sd2[i] <= '0;
        cb0[i] <= '0; ca1[i] <= '0; ca2[i] <= '0;
        psum[i] <= '0; ppeak[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_STEREO) stereo_mode <= cfg_data[0];
        else band_count <= cfg_data;
      end
      case (state)
        S_IDLE: if (in_valid) begin
          xp <= primary_sample;
          xs <= secondary_sample;
          hop <= hop_end;
          nbands <= bands_in_use;
          band <= '0;
          chan <= 1'b0;
          case (opcode)
            OP_AUDIO: state <= S_FILT;
            OP_LOAD: begin
              if (32'(coef_band) < BANDS) begin
                cb0[BW'(coef_band)] <= coef_gain;
                ca1[BW'(coef_band)] <= coef_fb_one;
                ca2[BW'(coef_band)] <= coef_fb_two;
              end
              state <= S_DONE;
            end
            OP_CLEAR: state <= S_CLEAR;
            default: state <= S_DONE;
          endcase
        end
        S_FILT: state <= S_WAIT;
        S_WAIT: if (bq_done) begin
          if (chan) begin
            sd1[band] <= bq_d1n; sd2[band] <= bq_d2n;
          end else begin
            pd1[band] <= bq_d1n; pd2[band] <= bq_d2n;
            sq_p <= sq;
          end
          if (!chan && stereo_mode) begin
            chan <= 1'b1;
            state <= S_FILT;
          end else begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          psum[band] <= sum_add[63] ? {63{1'b1}} : sum_add[62:0];
          if (64'(pw) > 64'(ppeak[band])) ppeak[band] <= PKB'(pw);
          chan <= 1'b0;
          if ((BW+1)'(band) + (BW+1)'(1) == nbands) begin
            band <= '0;
            if (hop_samples != {COUNT_BITS{1'b1}}) hop_samples <= hop_samples + 1'b1;
            state <= hop ? S_EMIT : S_IDLE;
          end else begin
            band <= band + 1'b1;
            state <= S_FILT;
          end
        end
        S_EMIT: if (out_ready) begin
          if (last) begin
            for (int i = 0; i < BANDS; i++) begin
              psum[i] <= '0; ppeak[i] <= '0;
            end
            hop_samples <= '0;
            band <= '0;
            state <= S_IDLE;
          end else begin
            band <= band + 1'b1;
          end
        end
        S_CLEAR: begin
          pd1[band] <= '0; pd2[band] <= '0; sd1[band] <= '0; sd2[band] <= '0;
          if (32'(band) == BANDS - 1) begin
            band <= '0;
            state <= S_IDLE;
          end else begin
            band <= band + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### dv/bandpass_filter_bank_power_meter_test.sv
// Self-checking testbench for the band-pass filter bank power meter.
module bandpass_filter_bank_power_meter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bpfb_pkg::*;

  localparam int NB = 16;
  localparam longint SUM_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  logic clk, rst;
  logic cfg_we, cfg_index;
  logic [4:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] opcode;
  logic signed [23:0] primary_sample, secondary_sample;
  logic hop_end;
  logic [3:0] coef_band;
  logic signed [27:0] coef_gain, coef_fb_one, coef_fb_two;
  logic out_valid, out_ready;
  logic [3:0] band_index;
  logic [46:0] peak_power;
  logic [62:0] sum_power;
  logic [15:0] sample_count;
  logic last;

  bandpass_filter_bank_power_meter DUT (.*);

  typedef struct packed {
    logic [3:0]  band;
    logic [46:0] peak;
    logic [62:0] sum;
    logic [15:0] count;
    logic        last;
  } meter_word_t;

  meter_word_t meter_queue[$];
  int errors;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;

  // predictor state
  bit mdl_stereo;
  logic [4:0] mdl_bands;
  longint p_d1[NB], p_d2[NB], s_d1[NB], s_d2[NB];
  longint g_b0[NB], g_a1[NB], g_a2[NB];
  longint unsigned acc_sum[NB], acc_peak[NB];
  int hop_cnt;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint sat(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // one biquad step, arithmetic shifts floor
  function automatic longint run_biquad(int b, longint x, inout longint d1, inout longint d2);
    longint fwd, y, yq;
    fwd = (g_b0[b] * x) >>> 15;
    y = fwd + d1;
    yq = sat(y >>> GUARD_BITS, 24);
    d1 = sat(d2 - ((g_a1[b] * yq) >>> 15), 40);
    d2 = sat(-fwd - ((g_a2[b] * yq) >>> 15), 40);
    return yq;
  endfunction

  task automatic predict_word(logic [1:0] op, longint xp, longint xs, bit he, int cb,
                             longint b0, longint a1, longint a2);
    int n;
    longint yp, ys;
    longint unsigned pw;
    meter_word_t w;
    if (op == OP_LOAD) begin
      g_b0[cb] = b0; g_a1[cb] = a1; g_a2[cb] = a2;
      return;
    end
    if (op == OP_CLEAR) begin
      for (int b = 0; b < NB; b++) begin
        p_d1[b] = 0; p_d2[b] = 0; s_d1[b] = 0; s_d2[b] = 0;
      end
      return;
    end
    if (op != OP_AUDIO) return;
    n = (mdl_bands == 0) ? 1 : (mdl_bands > NB) ? NB : mdl_bands;
    for (int b = 0; b < n; b++) begin
      yp = run_biquad(b, xp, p_d1[b], p_d2[b]);
      pw = yp * yp;
      if (mdl_stereo) begin
        ys = run_biquad(b, xs, s_d1[b], s_d2[b]);
        pw = (pw + longint'(ys * ys)) >> 1;
      end
      acc_sum[b] = (acc_sum[b] > SUM_LIMIT - pw) ? SUM_LIMIT : acc_sum[b] + pw;
      if (pw > acc_peak[b]) acc_peak[b] = pw;
    end
    if (hop_cnt < 65535) hop_cnt++;
    if (!he) return;
    for (int b = 0; b < n; b++) begin
      w.band = 4'(b); w.peak = 47'(acc_peak[b]); w.sum = 63'(acc_sum[b]);
      w.count = 16'(hop_cnt); w.last = (b == n - 1);
      meter_queue = {meter_queue, w};
    end
    for (int b = 0; b < NB; b++) begin
      acc_sum[b] = 0; acc_peak[b] = 0;
    end
    hop_cnt = 0;
  endtask

  task automatic send_word(logic [1:0] op, logic [23:0] xp, logic [23:0] xs, bit he,
                           logic [3:0] cb, logic [27:0] b0, logic [27:0] a1, logic [27:0] a2);
    @(posedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    opcode <= op; primary_sample <= xp; secondary_sample <= xs; hop_end <= he;
    coef_band <= cb; coef_gain <= b0; coef_fb_one <= a1; coef_fb_two <= a2;
    in_valid <= 1;
    predict_word(op, longint'($signed(xp)), longint'($signed(xs)), he, cb,
                 longint'($signed(b0)), longint'($signed(a1)), longint'($signed(a2)));
    do @(posedge clk); while (!in_ready);
    in_valid <= 0;
  endtask

  task automatic send_audio(logic [23:0] xp, logic [23:0] xs, bit he);
    send_word(OP_AUDIO, xp, xs, he, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic load_band(int b, logic [27:0] b0, logic [27:0] a1, logic [27:0] a2);
    send_word(OP_LOAD, $urandom, $urandom, $urandom, b, b0, a1, a2);
  endtask

  // Stable band-pass-ish coefficients with random spread.
  task automatic load_random_bank();
    for (int b = 0; b < NB; b++)
      load_band(b, 28'(int'($urandom_range(0, 4_000_000))),
                28'(-int'($urandom_range(16_000_000, 33_000_000))),
                28'(int'($urandom_range(10_000_000, 16_000_000))));
  endtask

  task automatic wait_drained();
    while (meter_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_STEREO) mdl_stereo = val[0];
    else mdl_bands = val;
  endtask

  task automatic test_extremes();
    load_band(0, 28'h7FF_FFFF, 28'h800_0000, 28'h7FF_FFFF);
    load_band(1, 28'h800_0000, 28'h7FF_FFFF, 28'h800_0000);
    load_band(2, 28'd4_000_000, -28'd30_000_000, 28'd14_000_000);
    load_band(15, 28'h555_5555, 28'hAAA_AAAA, 28'd0);
    send_audio(24'h7F_FFFF, 24'h80_0000, 0);
    send_audio(24'h80_0000, 24'h7F_FFFF, 0);
    send_audio(24'h55_5555, 24'hAA_AAAA, 1);
    send_word(2'd3, 24'h7F_FFFF, 0, 1, 0, 0, 0, 0);
    send_audio(24'h7F_FFFF, 24'h7F_FFFF, 1);
    send_word(OP_CLEAR, 0, 0, 1, 0, 0, 0, 0);
    send_audio(24'h80_0000, 24'h80_0000, 1);
    send_audio(0, 0, 1);
  endtask

  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 3) send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
      else if (r < 5) send_word(2'd3, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom);
      else if (r < 8) load_band($urandom, $urandom, $urandom, $urandom);
      else if (r < 15) send_audio($urandom, $urandom, $urandom_range(3) == 0);
      else send_audio(24'(int'($urandom_range(0, 200_000)) - 100_000), $urandom,
                      $urandom_range(7) == 0);
    end
    send_audio($urandom, $urandom, 1);
  endtask

  task automatic test_stall_fill();
    hold_off = 1;
    for (int i = 0; i < 12; i++) send_audio($urandom, $urandom, 1);
    wait_drained();
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk) begin
    meter_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (meter_queue.size() == 0) begin
        $error("unexpected result word band %0d", band_index);
        errors++;
      end else begin
        e = meter_queue.pop_front();
        if (band_index !== e.band) begin
          $error("band_index exp %0d got %0d", e.band, band_index); errors++;
        end
        if (peak_power !== e.peak) begin
          $error("peak_power exp %0d got %0d", e.peak, peak_power); errors++;
        end
        if (sum_power !== e.sum) begin
          $error("sum_power exp %0d got %0d", e.sum, sum_power); errors++;
        end
        if (sample_count !== e.count) begin
          $error("sample_count exp %0d got %0d", e.count, sample_count); errors++;
        end
        if (last !== e.last) begin
          $error("last exp %0d got %0d", e.last, last); errors++;
        end
      end
    end
  end

  initial begin
    int hold_cycles;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 0;
        hold_cycles++;
        if (hold_cycles >= 3000) begin
          hold_off = 0;
          hold_cycles = 0;
        end
      end else begin
        out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    errors = 0; send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0; in_valid = 0;
    opcode = 0; primary_sample = 0; secondary_sample = 0; hop_end = 0;
    coef_band = 0; coef_gain = 0; coef_fb_one = 0; coef_fb_two = 0;
    mdl_stereo = 0; mdl_bands = 16; hop_cnt = 0;
    for (int b = 0; b < NB; b++) begin
      p_d1[b] = 0; p_d2[b] = 0; s_d1[b] = 0; s_d2[b] = 0;
      g_b0[b] = 0; g_a1[b] = 0; g_a2[b] = 0; acc_sum[b] = 0; acc_peak[b] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    test_extremes();
    wait_drained();
    write_reg(CFG_STEREO, 1);
    test_extremes();
    wait_drained();

    load_random_bank();
    write_reg(CFG_BANDS, 0);
    test_random(40);
    wait_drained();
    write_reg(CFG_STEREO, 0);
    write_reg(CFG_BANDS, 31);
    send_idle_pct = 75;
    test_random(60);
    wait_drained();
    write_reg(CFG_BANDS, 5);
    send_idle_pct = 0; recv_stall_pct = 75;
    test_random(100);
    wait_drained();
    write_reg(CFG_STEREO, 1);
    write_reg(CFG_BANDS, 16);
    send_idle_pct = 36; recv_stall_pct = 36;
    test_random(60);
    wait_drained();
    send_idle_pct = 0; recv_stall_pct = 0;
    test_stall_fill();
    write_reg(CFG_BANDS, 1);
    test_random(40);
    wait_drained();

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

### sim.f
rtl/bpfb_pkg.sv
rtl/bpfb_biquad.sv
rtl/bandpass_filter_bank_power_meter.sv
dv/bandpass_filter_bank_power_meter_test.sv
